[src/hafs_pkg.sv]
// ----------------------------------------------------------------------------
// hafs_pkg
// Shared types and codes for the handle allocator with LIFO free stack.
// ----------------------------------------------------------------------------
`default_nettype none

package hafs_pkg;

	// Field widths fixed by the item format
	localparam int HANDLE_W = 11;
	localparam int STATUS_W = 2;
	localparam int MODE_W   = 2;

	// Default capacity
	localparam int DEF_MAX_HANDLES = 1024;

	// Operation codes; the unused code behaves as a query
	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_LIVE = 2'd3;

	typedef enum logic {
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [HANDLE_W-1:0] handle_in;
	} in_item_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle_out;
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] free_depth;
	} out_item_t;

endpackage

`default_nettype wire

[src/hafs_ram.sv]
// ----------------------------------------------------------------------------
// hafs_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data held while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module hafs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[src/handle_allocator_free_stack_core.sv]
// Flow: an accepted item waits in the execute state until the output register
//   takes its result; no new item is accepted meanwhile. The live-bit and free-stack
//   memories are read in the accept cycle and written back as the result is registered.
// Reset: high-water mark, free count and control clear at once; no clearing
//   pass, since live bits above the high-water mark are never used.
// ----------------------------------------------------------------------------
// handle_allocator_free_stack_core
// Issues handles 1..MAX_HANDLES, reusing freed handles last-in first-out,
// with free and query checks against a live-bit memory.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_allocator_free_stack_core
	import hafs_pkg::*;
#(
	parameter int MAX_HANDLES = DEF_MAX_HANDLES
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_item
);

	localparam int CW   = $clog2(MAX_HANDLES + 1);
	localparam int AW   = $clog2(MAX_HANDLES);
	localparam int CMPW = (CW > HANDLE_W) ? CW : HANDLE_W;

	fsm_t                state_q, state_nxt;
	logic [MODE_W-1:0]   mode_s1;
	logic [HANDLE_W-1:0] handle_s1;
	logic [CW-1:0]       high_water_q, high_water_nxt;
	logic [CW-1:0]       free_count_q, free_count_nxt;
	logic                out_valid_q;
	out_item_t           out_item_q, result;

	logic                accept, done;
	logic [CMPW-1:0]     hin_ext, hidx_ext, fc_dec;
	logic                in_range;

	logic                live_we, live_wdata, live_rd;
	logic [AW-1:0]       live_waddr, live_raddr;
	logic                stk_we;
	logic [AW-1:0]       stk_waddr, stk_raddr;
	logic [CW-1:0]       stk_wdata, stk_rd;

	// Live-bit memory, one bit per handle at index handle-1
	hafs_ram #(
		.WIDTH(1),
		.DEPTH(MAX_HANDLES)
	) u_live (
		.clk  (clk),
		.we   (live_we),
		.waddr(live_waddr),
		.wdata(live_wdata),
		.re   (accept),
		.raddr(live_raddr),
		.rdata(live_rd)
	);

	// Free stack memory
	hafs_ram #(
		.WIDTH(CW),
		.DEPTH(MAX_HANDLES)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (accept),
		.raddr(stk_raddr),
		.rdata(stk_rd)
	);

	// Read addresses: live bit from the incoming item's handle, stack top from the free count
	assign hidx_ext   = CMPW'(in_item.handle_in) - CMPW'(1);
	assign live_raddr = hidx_ext[AW-1:0];
	assign fc_dec     = CMPW'(free_count_q) - CMPW'(1);
	assign stk_raddr  = fc_dec[AW-1:0];

	// Range check on the held item
	assign hin_ext  = CMPW'(handle_s1);
	assign in_range = (handle_s1 != '0) && (hin_ext <= CMPW'(high_water_q));

	// Next state, memory writes and result
	always_comb begin
		logic [CMPW-1:0] widx;
		logic [CW-1:0]   hw_inc;
		state_nxt      = state_q;
		accept         = 1'b0;
		done           = 1'b0;
		in_stall       = 1'b0;
		high_water_nxt = high_water_q;
		free_count_nxt = free_count_q;
		live_we        = 1'b0;
		live_wdata     = 1'b0;
		live_waddr     = '0;
		stk_we         = 1'b0;
		stk_waddr      = free_count_q[AW-1:0];
		stk_wdata      = CW'(handle_s1);
		result         = '0;
		widx           = hin_ext - CMPW'(1);
		hw_inc         = high_water_q + CW'(1);
		unique case (state_q)
			FSM_IDLE: begin
				accept = in_valid;
				if (in_valid) begin
					state_nxt = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				in_stall = 1'b1;
				done     = !out_valid_q || !out_stall;
				if (done) begin
					state_nxt = FSM_IDLE;
				end
				case (mode_s1)
					MODE_ALLOC: begin
						if (free_count_q != '0) begin
							free_count_nxt    = free_count_q - CW'(1);
							live_we           = done;
							live_wdata        = 1'b1;
							widx              = CMPW'(stk_rd) - CMPW'(1);
							live_waddr        = widx[AW-1:0];
							result.handle_out = HANDLE_W'(stk_rd);
							result.status     = ST_OK;
						end else if (high_water_q < CW'(MAX_HANDLES)) begin
							high_water_nxt    = hw_inc;
							live_we           = done;
							live_wdata        = 1'b1;
							live_waddr        = high_water_q[AW-1:0];
							result.handle_out = HANDLE_W'(hw_inc);
							result.status     = ST_OK;
						end else begin
							result.status = ST_FULL;
						end
					end
					default: begin
						if (!in_range) begin
							result.status = ST_RANGE;
						end else if (!live_rd) begin
							result.status = ST_NOT_LIVE;
						end else begin
							result.handle_out = handle_s1;
							result.status     = ST_OK;
							if (mode_s1 == MODE_FREE) begin
								live_we    = done;
								live_wdata = 1'b0;
								live_waddr = widx[AW-1:0];
								if (free_count_q < CW'(MAX_HANDLES)) begin
									stk_we         = done;
									free_count_nxt = free_count_q + CW'(1);
								end
							end
						end
					end
				endcase
				result.free_depth = HANDLE_W'(free_count_nxt);
			end
			default: begin
				state_nxt = FSM_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FSM_IDLE;
			high_water_q <= '0;
			free_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (done) begin
				high_water_q <= high_water_nxt;
				free_count_q <= free_count_nxt;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the accepted item and the finished result
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= in_item.mode;
			handle_s1 <= in_item.handle_in;
		end
		if (done) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef NO_ASSERTIONS
	// A result appears only after an execute cycle
	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == FSM_EXEC))
		else $error("result without execute cycle");

	// An accepted item moves the block into execute
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == FSM_EXEC))
		else $error("accepted item did not enter execute");

	// Every stacked handle was issued, so the stack never exceeds the mark
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= high_water_q)
		else $error("free stack deeper than high-water mark");

	// High-water mark stays within capacity
	a_hw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		high_water_q <= CW'(MAX_HANDLES))
		else $error("high-water mark above capacity");
`endif

endmodule

`default_nettype wire
